@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file mi3_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define CHK_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

@@ rtl/core/mi3_pkg.sv @@
package mi3_pkg;

	// element format on the ports
	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic signed [ELEM_W-1:0] c0_x;
		logic signed [ELEM_W-1:0] c0_y;
		logic signed [ELEM_W-1:0] c0_z;
		logic signed [ELEM_W-1:0] c1_x;
		logic signed [ELEM_W-1:0] c1_y;
		logic signed [ELEM_W-1:0] c1_z;
		logic signed [ELEM_W-1:0] c2_x;
		logic signed [ELEM_W-1:0] c2_y;
		logic signed [ELEM_W-1:0] c2_z;
	} mat_in_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv_c0_x;
		logic signed [ELEM_W-1:0] inv_c0_y;
		logic signed [ELEM_W-1:0] inv_c0_z;
		logic signed [ELEM_W-1:0] inv_c1_x;
		logic signed [ELEM_W-1:0] inv_c1_y;
		logic signed [ELEM_W-1:0] inv_c1_z;
		logic signed [ELEM_W-1:0] inv_c2_x;
		logic signed [ELEM_W-1:0] inv_c2_y;
		logic signed [ELEM_W-1:0] inv_c2_z;
		logic signed [ELEM_W-1:0] determinant;
		logic                     singular;
		logic                     saturated;
	} mat_out_t;

endpackage

@@ rtl/core/matrix3_inverse.sv @@
// 3x3 matrix inverse and determinant, signed fixed point (adjugate method)
//
// mat channel: one matrix per transfer, nine elements given column by column
// res channel: inverse (same column order), determinant, singular, saturated
// both channels use valid/stall; a transfer happens when valid is high and
// stall is low at a rising clock edge
//
// throughput: one matrix per cycle while mat_stall is low, set by the fully
// pipelined datapath; the divider gives one quotient bit per stage, over
// ELEM_W + 1 stages
//
// a zero determinant gives singular = 1, a zero inverse and a zero
// determinant; results out of range clip and raise saturated
//
// reset (arst_n low) empties the pipeline and the output buffer at once
// when the receiver stalls, the result holds in the output register and one
// more result lands in a skid register; only then does mat_stall rise and
// the whole pipeline freeze, so nothing is dropped or repeated
module matrix3_inverse import mi3_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     mat_valid,
	output logic     mat_stall,
	input  mat_in_t  mat,
	output logic     res_valid,
	input  logic     res_stall,
	output mat_out_t res
);

	localparam int W   = ELEM_W;
	localparam int PW  = 2 * W;                      // element product
	localparam int CW  = 2 * W + 1;                  // cofactor
	localparam int HW  = 2 * W + 1;                  // det partial product
	localparam int TW  = 3 * W + 1;                  // det term
	localparam int DW  = 3 * W + 3;                  // determinant
	localparam int QB  = W + 1;                      // quotient bits kept
	localparam int NW  = CW + 2 * FRACTION_BITS + 1; // doubled numerator
	localparam int TPW = NW - QB;                    // numerator above quotient bits
	localparam int DRW = DW + 1 - 2 * FRACTION_BITS; // rounded determinant
	localparam int NST = QB + 8;                     // pipeline stages before output

	// adjugate entry k = col*3 + row is elem[PA]*elem[PB] - elem[MA]*elem[MB]
	localparam int PA [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
	localparam int PB [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
	localparam int MA [9] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
	localparam int MB [9] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

	localparam logic [QB-1:0]  LIMQ = QB'(1) << (W - 1);
	localparam logic [DRW-1:0] LIMD = DRW'(1) << (W - 1);
	localparam logic [W-1:0]   MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0]   MINV = {1'b1, {(W - 1){1'b0}}};

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] nlow;
		logic [QB-1:0] quo;
		logic          ovf;
		logic          neg;
	} lane_t;

	typedef struct packed {
		lane_t [8:0]    lane;
		logic [DW-1:0]  dmag;
		logic           dneg;
		logic           dzero;
		logic [DRW-1:0] drnd;
	} dstage_t;

	// one restoring step per lane: next quotient bit and remainder
	function automatic dstage_t div_step(dstage_t x);
		dstage_t     y;
		logic [DW:0] r;
		logic [DW:0] diff;
		logic        ge;
		y = x;
		for (int l = 0; l < 9; l++) begin
			r    = {x.lane[l].rem, x.lane[l].nlow[QB-1]};
			diff = r - {1'b0, x.dmag};
			ge   = (r >= {1'b0, x.dmag});
			y.lane[l].rem  = ge ? diff[DW-1:0] : r[DW-1:0];
			y.lane[l].nlow = {x.lane[l].nlow[QB-2:0], 1'b0};
			y.lane[l].quo  = {x.lane[l].quo[QB-2:0], ge};
		end
		return y;
	endfunction

	logic                 adv;
	logic [NST-1:0]       vld_s;
	logic signed [W-1:0]  elem [9];

	logic signed [PW-1:0] pp_s1 [9];
	logic signed [PW-1:0] pm_s1 [9];
	logic signed [W-1:0]  col0_s1 [3];
	logic signed [W-1:0]  col0_s2 [3];
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [CW-1:0] cof_s3 [9];
	logic signed [CW-1:0] cof_s4 [9];
	logic signed [CW-1:0] cof_s5 [9];
	logic signed [HW-1:0] pl_s3 [3];
	logic signed [HW-1:0] ph_s3 [3];
	logic signed [TW-1:0] term_s4 [3];
	logic signed [DW-1:0] det_s5;
	logic [DW-1:0]        dmag_s6;
	logic                 dneg_s6;
	logic                 dzero_s6;
	logic [CW-1:0]        cmag_s6 [9];
	logic                 cneg_s6 [9];

	dstage_t              div_in;
	dstage_t              div_s [QB+1];

	mat_out_t             fin_d;
	mat_out_t             fin_s;
	mat_out_t             out_q;
	mat_out_t             skid_q;
	logic                 out_v_q;
	logic                 skid_v_q;
	logic                 drain;
	logic                 take;

	// the pipeline moves only while the skid register is free
	assign adv       = !skid_v_q;
	assign mat_stall = skid_v_q;
	assign res_valid = out_v_q;
	assign res       = out_q;

	assign elem[0] = mat.c0_x;
	assign elem[1] = mat.c0_y;
	assign elem[2] = mat.c0_z;
	assign elem[3] = mat.c1_x;
	assign elem[4] = mat.c1_y;
	assign elem[5] = mat.c1_z;
	assign elem[6] = mat.c2_x;
	assign elem[7] = mat.c2_y;
	assign elem[8] = mat.c2_z;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], mat_valid};
		end
	end

	// stages 1 to 6: cross products, determinant, magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				pp_s1[k]   <= elem[PA[k]] * elem[PB[k]];
				pm_s1[k]   <= elem[MA[k]] * elem[MB[k]];
				cof_s2[k]  <= {pp_s1[k][PW-1], pp_s1[k]} - {pm_s1[k][PW-1], pm_s1[k]};
				cof_s3[k]  <= cof_s2[k];
				cof_s4[k]  <= cof_s3[k];
				cof_s5[k]  <= cof_s4[k];
				cneg_s6[k] <= cof_s5[k][CW-1];
				cmag_s6[k] <= cof_s5[k][CW-1] ? $unsigned(-cof_s5[k]) : $unsigned(cof_s5[k]);
			end
			for (int j = 0; j < 3; j++) begin
				col0_s1[j] <= elem[j];
				col0_s2[j] <= col0_s1[j];
				// the 32 x 65 product is split in two halves
				pl_s3[j]   <= $signed({1'b0, cof_s2[3*j][W-1:0]}) * col0_s2[j];
				ph_s3[j]   <= $signed(cof_s2[3*j][CW-1:W]) * col0_s2[j];
				term_s4[j] <= {ph_s3[j], {W{1'b0}}} + {{W{pl_s3[j][HW-1]}}, pl_s3[j]};
			end
			det_s5   <= {{2{term_s4[0][TW-1]}}, term_s4[0]}
				+ {{2{term_s4[1][TW-1]}}, term_s4[1]}
				+ {{2{term_s4[2][TW-1]}}, term_s4[2]};
			dneg_s6  <= det_s5[DW-1];
			dmag_s6  <= det_s5[DW-1] ? $unsigned(-det_s5) : $unsigned(det_s5);
			dzero_s6 <= (det_s5 == '0);
		end
	end

	// stage 7: divider setup, overflow check and determinant rounding
	always_comb begin : p_div_in
		logic [NW-1:0] n2;
		logic [DW:0]   dsum;
		div_in = '0;
		for (int k = 0; k < 9; k++) begin
			n2 = {cmag_s6[k], {(2 * FRACTION_BITS + 1){1'b0}}};
			div_in.lane[k].rem  = {{(DW - TPW){1'b0}}, n2[NW-1:QB]};
			div_in.lane[k].nlow = n2[QB-1:0];
			div_in.lane[k].quo  = '0;
			// quotient would need more bits than kept: certain to clip
			div_in.lane[k].ovf  = ({{(DW - TPW){1'b0}}, n2[NW-1:QB]} >= dmag_s6);
			div_in.lane[k].neg  = cneg_s6[k] ^ dneg_s6;
		end
		dsum         = {1'b0, dmag_s6} + ((DW + 1)'(1) << (2 * FRACTION_BITS - 1));
		div_in.dmag  = dmag_s6;
		div_in.dneg  = dneg_s6;
		div_in.dzero = dzero_s6;
		div_in.drnd  = dsum[DW:2*FRACTION_BITS];
	end

	// divider: one quotient bit of twice the ratio per stage
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_in;
			for (int d = 1; d <= QB; d++) begin
				div_s[d] <= div_step(div_s[d-1]);
			end
		end
	end

	// last stage: round half away from zero, apply sign, clip
	always_comb begin : p_fin
		logic [QB:0]         rsum;
		logic [QB-1:0]       qr;
		logic                lneg;
		logic                lsat;
		logic [8:0]          sat_v;
		logic signed [W-1:0] inv [9];
		logic                dsat;
		logic [W-1:0]        dval;
		for (int k = 0; k < 9; k++) begin
			rsum = {1'b0, div_s[QB].lane[k].quo} + (QB + 1)'(1);
			qr   = rsum[QB:1];
			lneg = div_s[QB].lane[k].neg;
			lsat = div_s[QB].lane[k].ovf | (lneg ? (qr > LIMQ) : (qr >= LIMQ));
			if (div_s[QB].dzero) begin
				inv[k]   = '0;
				sat_v[k] = 1'b0;
			end else if (lsat) begin
				inv[k]   = lneg ? MINV : MAXV;
				sat_v[k] = 1'b1;
			end else begin
				inv[k]   = lneg ? -qr[W-1:0] : qr[W-1:0];
				sat_v[k] = 1'b0;
			end
		end
		dsat = div_s[QB].dneg ? (div_s[QB].drnd > LIMD) : (div_s[QB].drnd >= LIMD);
		if (dsat) begin
			dval = div_s[QB].dneg ? MINV : MAXV;
		end else begin
			dval = div_s[QB].dneg ? -div_s[QB].drnd[W-1:0] : div_s[QB].drnd[W-1:0];
		end
		fin_d.inv_c0_x    = inv[0];
		fin_d.inv_c0_y    = inv[1];
		fin_d.inv_c0_z    = inv[2];
		fin_d.inv_c1_x    = inv[3];
		fin_d.inv_c1_y    = inv[4];
		fin_d.inv_c1_z    = inv[5];
		fin_d.inv_c2_x    = inv[6];
		fin_d.inv_c2_y    = inv[7];
		fin_d.inv_c2_z    = inv[8];
		fin_d.determinant = dval;
		fin_d.singular    = div_s[QB].dzero;
		fin_d.saturated   = dsat | (|sat_v);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s <= fin_d;
		end
	end

	// output register plus skid register
	assign drain = out_v_q && !res_stall;
	assign take  = adv && vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_v_q || drain) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (take) begin
			if (!out_v_q || drain) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (drain) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_v_q || drain) begin
				out_q <= skid_q;
			end
		end else if (take) begin
			if (!out_v_q || drain) begin
				out_q <= fin_s;
			end else begin
				skid_q <= fin_s;
			end
		end
	end

endmodule

@@ rtl/core/mi3_checker.sv @@
`include "assert_macros.svh"

module mi3_checker import mi3_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     mat_valid,
	input logic     mat_stall,
	input mat_in_t  mat,
	input logic     res_valid,
	input logic     res_stall,
	input mat_out_t res
);

	logic inv_zero;
	logic all_zero;
	logic sing_out;
	logic res_wait;
	logic mat_wait;

	assign inv_zero = (res.inv_c0_x == '0) && (res.inv_c0_y == '0) && (res.inv_c0_z == '0)
		&& (res.inv_c1_x == '0) && (res.inv_c1_y == '0) && (res.inv_c1_z == '0)
		&& (res.inv_c2_x == '0) && (res.inv_c2_y == '0) && (res.inv_c2_z == '0);
	assign all_zero = inv_zero && (res.determinant == '0);

	assign sing_out = res_valid && res.singular;
	assign res_wait = res_valid && res_stall;
	assign mat_wait = mat_valid && mat_stall;

	`CHK_ASSERT(a_sing_zero, clk, arst_n, sing_out |-> all_zero, "singular result with nonzero outputs")
	`CHK_ASSERT(a_sing_nosat, clk, arst_n, sing_out |-> !res.saturated, "singular result saturated")
	`CHK_ASSERT(a_res_hold, clk, arst_n, res_wait |=> res_valid && $stable(res), "stalled result changed")
	`CHK_ASSERT(a_in_hold, clk, arst_n, mat_wait |=> mat_valid && $stable(mat), "stalled input changed")
	`CHK_ASSERT_ALWAYS(a_stall_src, clk, $rose(mat_stall) |-> $past(res_wait), "unexpected input stall")

endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (.*);
